// ===== rtl/sfd_pkg.sv =====
package sfd_pkg;

  // Default frame length in 16-bit words, checksum word included
  localparam int FrameWordsDef = 11;

  // Reset value of the start word register
  localparam logic [15:0] StartWordRst = 16'hABCD;

  // Number of data words carried in one result
  localparam int OutWords = 9;

  // Width of the packed result on the output stream (bytes, zero padded)
  localparam int OutDataW = ((1 + 16 * OutWords + 7) / 8) * 8;

  // One decoded frame
  typedef struct packed {
    logic [15:0]        led_command;
    logic signed [15:0] board_temperature;
    logic signed [15:0] battery_voltage;
    logic signed [15:0] left_wheel_count;
    logic signed [15:0] right_wheel_count;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [15:0] command_two;
    logic signed [15:0] command_one;
    logic               checksum_ok;
  } sfd_res_t;

  // Status from the assembler to the output stage
  typedef struct packed {
    logic done;      // this byte completes a frame
    logic near_end;  // the next byte may complete a frame
  } sfd_stat_t;

endpackage

// ===== rtl/sfd_assembler.sv =====
module sfd_assembler #(
  parameter int FRAME_WORDS = sfd_pkg::FrameWordsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        byte_in,
  input  logic [15:0]       start_word,
  output sfd_pkg::sfd_stat_t stat,
  output sfd_pkg::sfd_res_t  res
);
  import sfd_pkg::*;

  localparam int Total = 2 * FRAME_WORDS;
  localparam int CntW  = $clog2(Total);
  localparam int WrdW  = CntW - 1;
  localparam int Depth = FRAME_WORDS - 2;

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic [7:0]      lo_r, lo_nxt;
  logic [15:0]     acc_r, acc_nxt;
  logic [15:0]     words_r [Depth];

  logic [15:0]     pair;
  logic [15:0]     word;
  logic [WrdW-1:0] widx;
  logic            is_start;
  logic            wr_en;
  logic            done;
  logic [15:0]     out_words [OutWords];

  assign pair     = {byte_in, prev_r};
  assign word     = {byte_in, lo_r};
  assign widx     = cnt_r[CntW-1:1];
  assign is_start = (pair == start_word);

  // Frame sequencing: start detection, byte collection, checksum
  always_comb begin
    cnt_nxt  = cnt_r;
    prev_nxt = prev_r;
    lo_nxt   = lo_r;
    acc_nxt  = acc_r;
    wr_en    = 1'b0;
    done     = 1'b0;
    if (byte_vld) begin
      prev_nxt = byte_in;
      if (is_start) begin
        cnt_nxt = CntW'(2);
        acc_nxt = pair;
      end else if (cnt_r != '0) begin
        if (!cnt_r[0]) begin
          lo_nxt  = byte_in;
          cnt_nxt = cnt_r + CntW'(1);
        end else begin
          if (widx < WrdW'(FRAME_WORDS - 1)) begin
            acc_nxt = acc_r ^ word;
            wr_en   = 1'b1;
          end
          if (cnt_r == CntW'(Total - 1)) begin
            done    = 1'b1;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r + CntW'(1);
          end
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      prev_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      prev_r <= prev_nxt;
    end
  end

  // Hold payload: low byte, running XOR and data words
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    acc_r <= acc_nxt;
    for (int i = 0; i < Depth; i++) begin
      if (wr_en && (widx == WrdW'(i + 1))) begin
        words_r[i] <= word;
      end
    end
  end

  // Map stored words onto the result fields, zero where the frame is short
  for (genvar k = 0; k < OutWords; k++) begin : g_out
    if (k < Depth) begin : g_word
      assign out_words[k] = words_r[k];
    end else begin : g_zero
      assign out_words[k] = '0;
    end
  end

  assign res.checksum_ok       = (acc_r == word);
  assign res.command_one       = out_words[0];
  assign res.command_two       = out_words[1];
  assign res.right_speed       = out_words[2];
  assign res.left_speed        = out_words[3];
  assign res.right_wheel_count = out_words[4];
  assign res.left_wheel_count  = out_words[5];
  assign res.battery_voltage   = out_words[6];
  assign res.board_temperature = out_words[7];
  assign res.led_command       = out_words[8];

  assign stat.done     = done;
  assign stat.near_end = (cnt_r == CntW'(Total - 1));

endmodule

// ===== rtl/serial_feedback_deframer.sv =====
// A frame's result is registered onto out_* in the cycle after its last byte transfer.
// Throughput: one byte per cycle; input stalls only when the output register
// is full, not taken, and the next byte could complete a frame.
// Reset: synchronous, active low; clears the byte counter, the previous byte,
// the output valid and restores the start word to 0xABCD.
module serial_feedback_deframer #(
  parameter int FRAME_WORDS = sfd_pkg::FrameWordsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // rx_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // checksum_ok, command_one, command_two, right_speed, left_speed,
  // right_wheel_count, left_wheel_count, battery_voltage,
  // board_temperature, led_command, zero pad
  output logic [sfd_pkg::OutDataW-1:0] out_tdata,
  input  logic                        cfg_we,
  input  logic [15:0]                 cfg_wdata
);
  import sfd_pkg::*;

  logic [15:0] start_word_r;
  logic        out_vld_r;
  sfd_res_t    out_r;
  sfd_res_t    res;
  sfd_stat_t   stat;
  logic        in_xfer;

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = !out_vld_r || out_tready || !stat.near_end;

  // Start word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_word_r <= StartWordRst;
    end else if (cfg_we) begin
      start_word_r <= cfg_wdata;
    end
  end

  sfd_assembler #(
    .FRAME_WORDS(FRAME_WORDS)
  ) u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_vld   (in_xfer),
    .byte_in    (in_tdata),
    .start_word (start_word_r),
    .stat       (stat),
    .res        (res)
  );

  // Output valid: load on a completed frame, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stat.done) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OutDataW - $bits(sfd_res_t))'(0), out_r};

endmodule

// ===== verif/serial_feedback_deframer_test.sv =====
module serial_feedback_deframer_test;
  import sfd_pkg::*;

  localparam int FrameWords = FrameWordsDef;
  localparam int FrameBytes = 2 * FrameWords;
  localparam int ResW = $bits(sfd_res_t);
  localparam int CycleLimit = 400000;
  localparam int RandomBytes = 800;
  localparam int DrainCycles = 3;

  typedef logic [15:0] frame_t [FrameWords];

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we;
  logic [15:0]         cfg_wdata;

  // Frame predictor state
  logic [15:0] start_word_m = StartWordRst;
  logic [7:0]  last_rx_byte = '0;
  int          rx_byte_cnt = 0;
  logic [15:0] frame_buf [FrameWords];
  sfd_res_t    expected_frames [$];

  // Stimulus and flow control
  frame_t      tx_frame;
  logic [15:0] cur_start = StartWordRst;
  int          tx_max_gap = 0;
  int          rx_max_gap = 0;
  int          rx_hold = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  string word_name [OutWords] = '{"command_one", "command_two", "right_speed", "left_speed",
                                  "right_wheel_count", "left_wheel_count",
                                  "battery_voltage", "board_temperature", "led_command"};

  serial_feedback_deframer #(.FRAME_WORDS(FrameWords)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Advance the predictor by one received byte; queue a frame when it completes
  function automatic void assemble_byte(input logic [7:0] b);
    logic [15:0] pair;
    logic [15:0] x;
    sfd_res_t    r;
    int          i;
    int          w;
    pair = {b, last_rx_byte};
    if (pair == start_word_m) begin
      frame_buf[0] = pair;
      rx_byte_cnt = 2;
    end else if (rx_byte_cnt >= 2 && rx_byte_cnt < FrameBytes) begin
      w = rx_byte_cnt / 2;
      if (rx_byte_cnt % 2 == 0) frame_buf[w][7:0] = b;
      else frame_buf[w][15:8] = b;
      rx_byte_cnt++;
    end
    if (rx_byte_cnt == FrameBytes) begin
      x = '0;
      for (i = 0; i < FrameWords - 1; i++) x ^= frame_buf[i];
      r = '0;
      r.checksum_ok = (x == frame_buf[FrameWords-1]);
      // Words that would be the checksum or lie past the frame stay zero
      for (i = 1; i <= OutWords; i++)
        if (i + 1 < FrameWords) r[1 + 16*(i-1) +: 16] = frame_buf[i];
      expected_frames.push_back(r);
      rx_byte_cnt = 0;
    end
    last_rx_byte = b;
  endfunction

  // Compare one result transfer with the oldest expected frame
  task automatic check_frame(input logic [OutDataW-1:0] got);
    sfd_res_t want;
    sfd_res_t seen;
    int       i;
    seen = got[ResW-1:0];
    if (expected_frames.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      mismatch_count++;
      return;
    end
    want = expected_frames.pop_front();
    if (seen.checksum_ok !== want.checksum_ok) begin
      $display("%0t: checksum_ok mismatch: expected %b, actual %b", $time,
               want.checksum_ok, seen.checksum_ok);
      mismatch_count++;
    end
    for (i = 0; i < OutWords; i++)
      if (seen[1 + 16*i +: 16] !== want[1 + 16*i +: 16]) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, word_name[i],
                 want[1 + 16*i +: 16], seen[1 + 16*i +: 16]);
        mismatch_count++;
      end
    if (got[OutDataW-1:ResW] !== '0) begin
      $display("%0t: pad mismatch: expected 0, actual %h", $time, got[OutDataW-1:ResW]);
      mismatch_count++;
    end
  endtask

  // Watch transfers and register writes at each rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) start_word_m = cfg_wdata;
      if (in_tvalid && in_tready) assemble_byte(in_tdata);
      if (out_tvalid && out_tready) check_frame(out_tdata);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls per transfer, plus a long hold-off on request
  initial begin : receiver
    int gap;
    out_tready = 1'b0;
    forever begin
      if (rx_hold > 0) begin
        out_tready = 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      gap = $urandom_range(0, rx_max_gap);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid && rx_hold == 0);
      @(negedge clk);
    end
  end

  // Send one byte after a random gap; return at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Send the first nbytes of tx_frame, low byte of each word first
  task automatic send_frame(input int nbytes);
    int k;
    for (k = 0; k < nbytes; k++)
      send_byte(k[0] ? tx_frame[k/2][15:8] : tx_frame[k/2][7:0]);
  endtask

  // Draw a word, biased toward the extremes
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Set the checksum word of tx_frame, flipping one bit when corrupt is set
  function automatic void seal_frame(input bit corrupt);
    logic [15:0] x;
    int          i;
    x = '0;
    for (i = 0; i < FrameWords - 1; i++) x ^= tx_frame[i];
    if (corrupt) x ^= 16'(1) << $urandom_range(0, 15);
    tx_frame[FrameWords-1] = x;
  endfunction

  function automatic void random_frame(input bit corrupt);
    int i;
    tx_frame[0] = cur_start;
    for (i = 1; i < FrameWords - 1; i++) tx_frame[i] = pick_word();
    seal_frame(corrupt);
  endfunction

  // Hold the sender until every expected frame has come out
  task automatic drain_results();
    in_tvalid = 1'b0;
    do @(posedge clk); while (expected_frames.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_start_word(input logic [15:0] v);
    drain_results();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cur_start = v;
  endtask

  // Noise, an extreme-valued frame, a cut frame, and a checksum that equals the start word
  task automatic test_directed_frames();
    int i;
    tx_max_gap = 0;
    rx_max_gap = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hCD);
    tx_frame = '{default: 16'h0000};
    tx_frame[0] = cur_start;
    tx_frame[1] = 16'h0000;
    tx_frame[2] = 16'hFFFF;
    tx_frame[3] = 16'h8000;
    tx_frame[4] = 16'h7FFF;
    tx_frame[5] = 16'h0001;
    tx_frame[6] = 16'hFFFE;
    tx_frame[7] = 16'h5555;
    tx_frame[8] = 16'hAAAA;
    tx_frame[9] = 16'hFFFF;
    seal_frame(1'b0);
    send_frame(FrameBytes);
    // Cut this frame short; the next start word reopens
    send_frame(7);
    // All-zero data makes the checksum equal the start word: restart, no result
    for (i = 1; i < FrameWords - 1; i++) tx_frame[i] = 16'h0000;
    seal_frame(1'b0);
    send_frame(FrameBytes);
    // Finish the reopened frame with a wrong checksum
    for (i = 1; i < FrameWords - 1; i++) tx_frame[i] = 16'(i * 16'h1111);
    seal_frame(1'b1);
    for (i = 2; i < FrameBytes; i++)
      send_byte(i[0] ? tx_frame[i/2][15:8] : tx_frame[i/2][7:0]);
    drain_results();
  endtask

  // Stop the receiver while back-to-back frames fill the block, then pause the sender
  task automatic test_output_backpressure();
    int n;
    tx_max_gap = 0;
    rx_max_gap = 0;
    rx_hold = 80;
    for (n = 0; n < 4; n++) begin
      random_frame(n[0]);
      send_frame(FrameBytes);
    end
    drain_results();
  endtask

  // Run frames under extreme and ordinary start words
  task automatic test_start_word_settings();
    logic [15:0] sw [4];
    int          s;
    int          n;
    sw = '{16'h0000, 16'hFFFF, 16'h00FF, 16'h5A3C};
    tx_max_gap = 10;
    rx_max_gap = 10;
    for (s = 0; s < 4; s++) begin
      write_start_word(sw[s]);
      send_byte(8'($urandom()));
      for (n = 0; n < 3; n++) begin
        random_frame(n == 2);
        send_frame(FrameBytes);
      end
    end
    write_start_word(StartWordRst);
  endtask

  // Mostly well-formed frames with random content, some noise, cut frames, bad checksums and start word changes
  task automatic test_random_traffic();
    int sent;
    int frames;
    int n;
    int k;
    sent = 0;
    frames = 0;
    while (sent < RandomBytes) begin
      if (frames % 10 == 0) begin
        tx_max_gap = $urandom_range(0, 1) ? 10 : 0;
        rx_max_gap = $urandom_range(0, 1) ? 10 : 0;
      end
      if (frames % 25 == 24) write_start_word(pick_word());
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++) send_byte(8'($urandom()));
        end
        1: begin
          random_frame(1'b0);
          n = $urandom_range(2, FrameBytes - 1);
          send_frame(n);
          sent += n;
        end
        2: begin
          random_frame(1'b1);
          send_frame(FrameBytes);
          sent += FrameBytes;
        end
        default: begin
          random_frame(1'b0);
          send_frame(FrameBytes);
          sent += FrameBytes;
        end
      endcase
      frames++;
    end
    drain_results();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_output_backpressure();
    test_start_word_settings();
    test_random_traffic();

    repeat (5) @(negedge clk);
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sfd_pkg.sv
rtl/sfd_assembler.sv
rtl/serial_feedback_deframer.sv
verif/serial_feedback_deframer_test.sv
